[rtl/orse_pkg.sv]
package orse_pkg;

   localparam int ROM_BYTES_DEF    = 8;
   localparam int FAMILY_LIMIT_DEF = 9;

   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 80;

   localparam int ROM_W  = 64;
   localparam int POS_W  = 7;
   localparam int CRC_W  = 8;
   localparam int ERR_W  = 3;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_START_FIRST = 2'd0,
      OP_START_NEXT  = 2'd1,
      OP_PRESENCE    = 2'd2,
      OP_TRIPLET     = 2'd3
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE        = 3'd0,
      ERR_NO_PRESENCE = 3'd1,
      ERR_NO_RESPONSE = 3'd2,
      ERR_CRC         = 3'd3,
      ERR_ZERO_FAMILY = 3'd4
   } err_type;

   // One classified beat as it waits between the front and the back.
   typedef struct packed {
      op_type op;
      logic   presence;
      logic   no_response;
      logic   zero_branch;
      logic   direction;
   } cmd_type;

endpackage

[rtl/onewire_rom_search_engine.sv]
// Channel  | Direction | Beat contents
// req      | in        | tuser[1:0] operation; tdata presence, id bit, complement bit, direction
// rsp      | out       | tlast finished; tdata request flags, ROM code, search state, error code
//
// One beat is taken per cycle while the queue has room, and each request beat yields exactly one response beat.
// A request is decoded into the two-entry queue at acceptance and carried out when it leaves
// the queue, once the output register is free; its response is then registered there.
// Reset clears the search state and the queue; the ROM search restarts from idle.
// A stalled response holds in the output register while the queue absorbs two more beats.
module onewire_rom_search_engine #(
   parameter int ROM_BYTES    = orse_pkg::ROM_BYTES_DEF,
   parameter int FAMILY_LIMIT = orse_pkg::FAMILY_LIMIT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] presence, [1] id_bit, [2] cmp_bit, [3] taken_direction, [7:4] zero.
   input  logic [orse_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] operation.
   input  logic [orse_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] next_direction, [1] need_reset, [2] need_triplet, [3] found,
   // [67:4] rom_code, [68] last_device, [75:69] family_discrepancy,
   // [78:76] error_code, [79] zero.
   output logic [orse_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // The finished flag.
   output logic                                rsp_tlast
);
   import orse_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   orse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop)
   );

   orse_back #(
      .ROM_BYTES    (ROM_BYTES),
      .FAMILY_LIMIT (FAMILY_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/orse_front.sv]
module orse_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [orse_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [orse_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                q_valid,
   output orse_pkg::cmd_type                   q_cmd,
   input  logic                                q_pop
);
   import orse_pkg::*;

   cmd_type     entry_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   cmd_type     cmd_new;
   logic        push;

   always_comb begin
      cmd_new.op          = op_type'(req_tuser[1:0]);
      cmd_new.presence    = req_tdata[0];
      cmd_new.no_response = req_tdata[1] & req_tdata[2];
      cmd_new.zero_branch = ~req_tdata[1] & ~req_tdata[2] & ~req_tdata[3];
      cmd_new.direction   = req_tdata[3];
   end

   assign req_tready = (count_ff != 2'(QUEUE_DEPTH));
   assign push       = req_tvalid & req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_cmd      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, q_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH))
      else $error("Queue count exceeds its depth.");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != 2'd0)
      else $error("Queue popped while empty.");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("Queue pointers disagree with the count.");

endmodule

[rtl/orse_back.sv]
module orse_back #(
   parameter int ROM_BYTES    = orse_pkg::ROM_BYTES_DEF,
   parameter int FAMILY_LIMIT = orse_pkg::FAMILY_LIMIT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  orse_pkg::cmd_type                   q_cmd,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [orse_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);
   import orse_pkg::*;

   localparam logic [POS_W-1:0] TOTAL_BITS = POS_W'(ROM_BYTES * 8);
   localparam logic [POS_W:0]   FAM_LIMIT  = (POS_W + 1)'(FAMILY_LIMIT);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_WAIT   = 3'b010,
      PH_SEARCH = 3'b100
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [ROM_W-1:0]   rom_ff, rom_in;
   logic [POS_W-1:0]   last_disc_ff, last_disc_in;
   logic [POS_W-1:0]   fam_disc_ff, fam_disc_in;
   logic               last_dev_ff, last_dev_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   zero_pos_ff, zero_pos_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;

   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff;

   logic               nd, nr, nt, fin, fnd, ignored;
   logic [ROM_W-1:0]   rom_out;
   err_type            err;
   logic [5:0]         bit_idx;
   logic [2:0]         byte_idx;

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [CRC_W-1:0] data);
      logic [CRC_W-1:0] v;
      v = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         v = v[0] ? ((v >> 1) ^ 8'h8C) : (v >> 1);
      end
      return v;
   endfunction

   function automatic logic dir_for(input logic [POS_W-1:0] pos,
                                    input logic [ROM_W-1:0] rom,
                                    input logic [POS_W-1:0] ld);
      logic [5:0] idx;
      idx = 6'(pos - 7'd1);
      if (pos < ld) begin
         return rom[idx];
      end
      return (pos == ld);
   endfunction

   assign q_pop = q_valid & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      phase_in     = phase_ff;
      rom_in       = rom_ff;
      last_disc_in = last_disc_ff;
      fam_disc_in  = fam_disc_ff;
      last_dev_in  = last_dev_ff;
      pos_in       = pos_ff;
      zero_pos_in  = zero_pos_ff;
      crc_in       = crc_ff;
      nd = 1'b0; nr = 1'b0; nt = 1'b0; fin = 1'b0; fnd = 1'b0; ignored = 1'b0;
      rom_out  = '0;
      err      = ERR_NONE;
      bit_idx  = 6'(pos_ff - 7'd1);
      byte_idx = 3'(pos_ff[5:3] - 3'd1);

      case (q_cmd.op)
         OP_START_FIRST, OP_START_NEXT: begin
            if (q_cmd.op == OP_START_FIRST) begin
               last_disc_in = '0;
               fam_disc_in  = '0;
               last_dev_in  = 1'b0;
            end
            pos_in       = 7'd1;
            zero_pos_in  = '0;
            crc_in       = '0;
            phase_in     = PH_IDLE;
            if (last_dev_in) begin
               last_disc_in = '0;
               fam_disc_in  = '0;
               last_dev_in  = 1'b0;
               fin          = 1'b1;
            end else begin
               phase_in = PH_WAIT;
               nr       = 1'b1;
            end
         end
         OP_PRESENCE: begin
            if (phase_ff != PH_WAIT) begin
               ignored = 1'b1;
            end else if (!q_cmd.presence) begin
               last_disc_in = '0;
               fam_disc_in  = '0;
               last_dev_in  = 1'b0;
               pos_in       = 7'd1;
               zero_pos_in  = '0;
               crc_in       = '0;
               phase_in     = PH_IDLE;
               fin          = 1'b1;
               err          = ERR_NO_PRESENCE;
            end else begin
               phase_in = PH_SEARCH;
               nt       = 1'b1;
               nd       = dir_for(pos_ff, rom_ff, last_disc_ff);
            end
         end
         OP_TRIPLET: begin
            if (phase_ff != PH_SEARCH) begin
               ignored = 1'b1;
            end else if (q_cmd.no_response) begin
               last_disc_in = '0;
               fam_disc_in  = '0;
               last_dev_in  = 1'b0;
               pos_in       = 7'd1;
               zero_pos_in  = '0;
               crc_in       = '0;
               phase_in     = PH_IDLE;
               fin          = 1'b1;
               err          = ERR_NO_RESPONSE;
            end else begin
               if (q_cmd.zero_branch) begin
                  zero_pos_in = pos_ff;
                  if ({1'b0, pos_ff} < FAM_LIMIT) begin
                     fam_disc_in = pos_ff;
                  end
               end
               rom_in[bit_idx] = q_cmd.direction;
               if (pos_ff[2:0] == 3'd0) begin
                  crc_in = crc_byte(crc_ff, rom_in[{byte_idx, 3'b000} +: 8]);
               end
               if (pos_ff >= TOTAL_BITS) begin
                  fin = 1'b1;
                  if (crc_in != '0) begin
                     last_disc_in = '0;
                     fam_disc_in  = '0;
                     last_dev_in  = 1'b0;
                     err          = ERR_CRC;
                  end else begin
                     last_disc_in = zero_pos_in;
                     if (zero_pos_in == '0) begin
                        last_dev_in = 1'b1;
                     end
                     if (rom_in[7:0] == 8'd0) begin
                        last_disc_in = '0;
                        fam_disc_in  = '0;
                        last_dev_in  = 1'b0;
                        err          = ERR_ZERO_FAMILY;
                     end else begin
                        fnd     = 1'b1;
                        rom_out = rom_in;
                     end
                  end
                  pos_in       = 7'd1;
                  zero_pos_in  = '0;
                  crc_in       = '0;
                  phase_in     = PH_IDLE;
               end else begin
                  pos_in = 7'(pos_ff + 7'd1);
                  nt     = 1'b1;
                  nd     = dir_for(pos_in, rom_in, last_disc_ff);
               end
            end
         end
         default: begin
            ignored = 1'b1;
         end
      endcase

      if (ignored) begin
         rsp_data_in = '0;
      end else begin
         rsp_data_in = {1'b0, err, fam_disc_in, last_dev_in, rom_out,
                        fnd, nt, nr, nd};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rom_ff       <= '0;
         last_disc_ff <= '0;
         fam_disc_ff  <= '0;
         last_dev_ff  <= 1'b0;
         pos_ff       <= 7'd1;
         zero_pos_ff  <= '0;
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff     <= phase_in;
            rom_ff       <= rom_in;
            last_disc_ff <= last_disc_in;
            fam_disc_ff  <= fam_disc_in;
            last_dev_ff  <= last_dev_in;
            pos_ff       <= pos_in;
            zero_pos_ff  <= zero_pos_in;
            crc_ff       <= crc_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= fin & ~ignored;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("Search phase is not one-hot.");

   a_found_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[3] |-> rsp_last_ff)
      else $error("A found beat must end the pass.");

   a_idle_restart: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> pos_ff == 7'd1 && crc_ff == '0 && zero_pos_ff == '0)
      else $error("Per-pass state not cleared while idle.");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff != '0 && pos_ff <= TOTAL_BITS)
      else $error("Bit position out of range.");

endmodule
